// ===== src/bsfd_pkg.sv =====
// ============================================================================
// bsfd_pkg: shared types and constants of the byte-stuffing frame decoder
// Holds the field widths, the phase and result-kind codes and the result
// record that the decoder queues toward its output channel.
// ============================================================================
package bsfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 1;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    // room for the largest burst of results one byte can cause
    localparam int MAX_BURST   = 2;

    localparam logic [BYTE_W-1:0] START_RESET  = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
    localparam logic [BYTE_W-1:0] COUNT_MAX    = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START  = 1'b0,
        CFG_ESCAPE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2,
        PH_DROP  = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_DATA    = 3'd0,
        K_DONE    = 3'd1,
        K_NOSTART = 3'd2,
        K_BADESC  = 3'd3,
        K_STARTIN = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic [BYTE_W-1:0]  count;
        logic               last;
    } t_result;

endpackage

// ===== src/bsfd_in_if.sv =====
// ============================================================================
// bsfd_in_if: received-byte channel
// Carries one encoded byte and its end-of-frame mark per transfer.
// ============================================================================
interface bsfd_in_if;
    import bsfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink   (input valid, input in_byte, input is_final, output ready);

endinterface

// ===== src/bsfd_out_if.sv =====
// ============================================================================
// bsfd_out_if: decoder result channel
// Carries one result (data byte, frame done or error) per transfer.
// ============================================================================
interface bsfd_out_if;
    import bsfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] byte_count;
    logic              last_of_run;

    modport source (output valid, output result_kind, output out_byte,
                    output byte_count, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input out_byte,
                    input byte_count, input last_of_run, output ready);

endinterface

// ===== src/byte_stuff_frame_decoder.sv =====
// ============================================================================
// byte_stuff_frame_decoder: byte-stuffing frame decoder
// Checks the start delimiter, removes escape prefixes, counts decoded bytes
// (saturating) and reports frame done or one error per frame.
// ============================================================================
//
//  channel      dir  modport  per transfer
//  ---------    ---  -------  ---------------------------------------------
//  i_in_chan    in   sink     in_byte, is_final
//  o_out_chan   out  source   result_kind, out_byte, byte_count, last_of_run
//  i_cfg_*      in   -        write enable, register index, 8-bit data
//
//  One byte is decoded per cycle while the input is ready; the phase/count
//  update is a single compare-and-increment between the state registers.
//  Results go into a 4-entry queue; a byte is taken while the queue has room
//  for two more results, so bytes flow at one per cycle as long as the sink
//  keeps up, and a data byte that closes a frame queues a second result.
//  Reset (synchronous, active low) empties the queue, restores the
//  delimiters and returns to waiting for a start byte.
// ============================================================================
module byte_stuff_frame_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bsfd_in_if.sink                        i_in_chan,
    bsfd_out_if.source                     o_out_chan,
    input  logic                           i_cfg_we,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsfd_pkg::BYTE_W-1:0]    i_cfg_data
);
    import bsfd_pkg::*;

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_escape_byte;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_count, n_count;

    t_result           r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic              in_xfer;
    logic              out_xfer;
    logic [1:0]        num_res;
    t_result           res0, res1;
    logic [BYTE_W-1:0] cnt_inc;
    logic [BYTE_W-1:0] b;
    logic              fin;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_RESET;
            r_escape_byte <= ESCAPE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START:  r_start_byte  <= i_cfg_data;
                CFG_ESCAPE: r_escape_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshakes
    assign i_in_chan.ready = (r_fill <= FILL_W'(QUEUE_DEPTH - MAX_BURST));
    assign in_xfer         = i_in_chan.valid && i_in_chan.ready;
    assign out_xfer        = o_out_chan.valid && o_out_chan.ready;

    assign b       = i_in_chan.in_byte;
    assign fin     = i_in_chan.is_final;
    assign cnt_inc = (r_count == COUNT_MAX) ? r_count : r_count + 8'd1;

    // decode one byte: next phase, next count and up to two results
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        num_res = 2'd0;
        res0    = '0;
        res1    = '0;
        case (r_phase)
            PH_IDLE: begin
                n_count = '0;
                if (b != r_start_byte) begin
                    res0.kind = K_NOSTART;
                    num_res   = 2'd1;
                    n_phase   = fin ? PH_IDLE : PH_DROP;
                end else if (fin) begin
                    res0.kind = K_DONE;
                    num_res   = 2'd1;
                    n_phase   = PH_IDLE;
                end else begin
                    n_phase = PH_FRAME;
                end
            end
            PH_FRAME, PH_ESC: begin
                if (r_phase == PH_FRAME && b == r_escape_byte) begin
                    if (fin) begin
                        res0.kind  = K_BADESC;
                        res0.count = r_count;
                        num_res    = 2'd1;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_phase = PH_ESC;
                    end
                end else if (r_phase == PH_FRAME && b == r_start_byte) begin
                    res0.kind  = K_STARTIN;
                    res0.count = r_count;
                    num_res    = 2'd1;
                    n_phase    = fin ? PH_IDLE : PH_DROP;
                end else if (r_phase == PH_ESC && b != r_escape_byte
                             && b != r_start_byte) begin
                    res0.kind  = K_BADESC;
                    res0.count = r_count;
                    num_res    = 2'd1;
                    n_phase    = fin ? PH_IDLE : PH_DROP;
                end else begin
                    // literal or unescaped data byte
                    n_count    = cnt_inc;
                    res0.kind  = K_DATA;
                    res0.data  = b;
                    res0.count = cnt_inc;
                    if (fin) begin
                        res1.kind  = K_DONE;
                        res1.count = cnt_inc;
                        num_res    = 2'd2;
                        n_phase    = PH_IDLE;
                    end else begin
                        num_res = 2'd1;
                        n_phase = PH_FRAME;
                    end
                end
            end
            default: begin
                if (fin) begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
        res0.last = (num_res == 2'd1);
        res1.last = 1'b1;
    end

    // decoder state: advance only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_xfer && num_res != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_xfer && num_res == 2'd2) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    assign n_fill = r_fill + (in_xfer ? FILL_W'(num_res) : FILL_W'(0))
                    - (out_xfer ? FILL_W'(1) : FILL_W'(0));

    // result queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (in_xfer) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(num_res);
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_fill <= n_fill;
        end
    end

    // present the queue head
    assign o_out_chan.valid       = (r_fill != '0);
    assign o_out_chan.result_kind = r_queue[r_rd_ptr].kind;
    assign o_out_chan.out_byte    = r_queue[r_rd_ptr].data;
    assign o_out_chan.byte_count  = r_queue[r_rd_ptr].count;
    assign o_out_chan.last_of_run = r_queue[r_rd_ptr].last;

    // queue never overfills
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // a frame-done result always closes its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_chan.valid && o_out_chan.result_kind == K_DONE)
            |-> o_out_chan.last_of_run)
        else $error("done result not marked last of run");

    // the final byte of a frame always returns the decoder to idle
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && fin) |=> (r_phase == PH_IDLE))
        else $error("decoder not idle after final byte");

    // hold off the input while the queue lacks room for a full burst
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill > FILL_W'(QUEUE_DEPTH - MAX_BURST)) |-> !i_in_chan.ready)
        else $error("input taken without room for a full burst");

endmodule

// ===== bench/bsfd_frame_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// bsfd_frame_checker: result predictor and comparator for the frame decoder
// Watches the byte channel, the result channel and the register writes.
// Every accepted byte is decoded here on a private copy of the phase, the
// count and the delimiters. Every accepted result is compared field by field
// with the oldest decoded result still waiting.
// ============================================================================
module bsfd_frame_checker
    import bsfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bsfd_in_if                   i_in_chan,
    bsfd_out_if                  i_out_chan,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // private decoder state and delimiter copies
    t_phase            frame_phase;
    logic [BYTE_W-1:0] frame_count;
    logic [BYTE_W-1:0] start_val;
    logic [BYTE_W-1:0] esc_val;

    t_result decoded_results[$];
    int      fail_total;

    function automatic t_result make_entry(input t_kind kind, input logic [BYTE_W-1:0] data,
                                           input logic [BYTE_W-1:0] count, input logic last);
        t_result r;
        r.kind  = kind;
        r.data  = data;
        r.count = count;
        r.last  = last;
        return r;
    endfunction

    // Decode one received byte and queue the results it causes
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic  has_err;
        logic  has_data;
        logic  done_only;
        t_kind err_kind;
        has_err   = 1'b0;
        has_data  = 1'b0;
        done_only = 1'b0;
        err_kind  = K_DATA;

        case (frame_phase)
            PH_IDLE: begin
                frame_count = '0;
                if (b != start_val) begin
                    has_err  = 1'b1;
                    err_kind = K_NOSTART;
                end else if (fin) begin
                    done_only = 1'b1;
                end else begin
                    frame_phase = PH_FRAME;
                end
            end
            PH_FRAME: begin
                // escape is checked first, so equal delimiters act as escape
                if (b == esc_val) begin
                    if (fin) begin
                        has_err  = 1'b1;
                        err_kind = K_BADESC;
                    end else begin
                        frame_phase = PH_ESC;
                    end
                end else if (b == start_val) begin
                    has_err  = 1'b1;
                    err_kind = K_STARTIN;
                end else begin
                    has_data = 1'b1;
                end
            end
            PH_ESC: begin
                if (b == esc_val || b == start_val) begin
                    has_data = 1'b1;
                end else begin
                    has_err  = 1'b1;
                    err_kind = K_BADESC;
                end
            end
            default: begin
                // drop silently up to the final mark
                if (fin) frame_phase = PH_IDLE;
            end
        endcase

        if (has_err) begin
            decoded_results.push_back(make_entry(err_kind, '0, frame_count, 1'b1));
            frame_phase = fin ? PH_IDLE : PH_DROP;
        end
        if (done_only) begin
            decoded_results.push_back(make_entry(K_DONE, '0, '0, 1'b1));
        end
        if (has_data) begin
            if (frame_count != COUNT_MAX) frame_count = frame_count + 1'b1;
            decoded_results.push_back(make_entry(K_DATA, b, frame_count, !fin));
            if (fin) begin
                decoded_results.push_back(make_entry(K_DONE, '0, frame_count, 1'b1));
                frame_phase = PH_IDLE;
            end else begin
                frame_phase = PH_FRAME;
            end
        end
    endtask

    // Compare one result transfer with the oldest waiting entry
    task automatic check_result();
        t_result want;
        if (decoded_results.size() == 0) begin
            $error("unexpected result: kind %0d byte %0d count %0d last %0d",
                   i_out_chan.result_kind, i_out_chan.out_byte,
                   i_out_chan.byte_count, i_out_chan.last_of_run);
            fail_total++;
        end else begin
            want = decoded_results.pop_front();
            if (i_out_chan.result_kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d",
                       want.kind, i_out_chan.result_kind);
                fail_total++;
            end
            if (i_out_chan.out_byte !== want.data) begin
                $error("out_byte: expected %0d, actual %0d", want.data, i_out_chan.out_byte);
                fail_total++;
            end
            if (i_out_chan.byte_count !== want.count) begin
                $error("byte_count: expected %0d, actual %0d",
                       want.count, i_out_chan.byte_count);
                fail_total++;
            end
            if (i_out_chan.last_of_run !== want.last) begin
                $error("last_of_run: expected %0d, actual %0d",
                       want.last, i_out_chan.last_of_run);
                fail_total++;
            end
        end
    endtask

    // Track writes, decode input transfers, check output transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_phase = PH_IDLE;
            frame_count = '0;
            start_val   = START_RESET;
            esc_val     = ESCAPE_RESET;
            decoded_results.delete();
            fail_total  = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_START:  start_val = i_cfg_data;
                    CFG_ESCAPE: esc_val   = i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_in_chan.valid && i_in_chan.ready) begin
                decode_byte(i_in_chan.in_byte, i_in_chan.is_final);
            end
            if (i_out_chan.valid && i_out_chan.ready) begin
                check_result();
            end
        end
        o_pending    <= decoded_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== bench/tb_byte_stuff_frame_decoder.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_byte_stuff_frame_decoder: regression bench of the frame decoder
// Runs a short directed script on the reset delimiters, then random frames
// (mostly well formed, some broken) under several delimiter settings,
// including both extremes and equal delimiters. Both channels idle in random
// bursts, and the result side holds off once long enough to stall the input.
// ============================================================================
module tb_byte_stuff_frame_decoder
    import bsfd_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_LEN       = 200;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_data;

    int fail_count;
    int results_pending;

    // stimulus bookkeeping shared with the result-side process
    int bytes_sent = 0;
    bit idle_on    = 1'b1;
    bit quiet      = 1'b0;

    logic [BYTE_W-1:0] cur_start = START_RESET;
    logic [BYTE_W-1:0] cur_esc   = ESCAPE_RESET;

    // {is_final, in_byte} on the reset delimiters 7E (start) / 7D (escape)
    logic [8:0] directed_seq [23] = '{
        9'h17E,                                 // start-only frame
        9'h000, 9'h1FF,                         // missing start, then drop
        9'h07E, 9'h000, 9'h1FF,                 // data extremes, data on final
        9'h07E, 9'h07D, 9'h07E, 9'h07D, 9'h17D, // both escaped literals
        9'h07E, 9'h041, 9'h07E, 9'h142,         // start inside frame, drop
        9'h07E, 9'h07D, 9'h133,                 // bad escape on final byte
        9'h07E, 9'h17D,                         // escape on final byte
        9'h155,                                 // missing start on final
        9'h07E, 9'h17E                          // start inside, on final
    };

    bsfd_in_if  in_ch();
    bsfd_out_if out_ch();

    byte_stuff_frame_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_ch),
        .o_out_chan (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bsfd_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_chan    (in_ch),
        .i_out_chan   (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one byte, optionally after an idle burst, and wait for its transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.is_final <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // Payload byte biased toward the delimiters
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return cur_start;
            1:       return cur_esc;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Encode and send one well-formed frame of n payload bytes
    task automatic send_frame(input int n);
        logic [BYTE_W-1:0] p;
        send_byte(cur_start, n == 0);
        for (int i = 0; i < n; i++) begin
            p = pick_byte();
            if (p == cur_start || p == cur_esc) send_byte(cur_esc, 1'b0);
            send_byte(p, i == n - 1);
        end
    endtask

    // Send a broken or noisy run that ends on a final mark
    task automatic send_noise(input int n);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < n; i++) begin
            b = (i == 0 && $urandom_range(0, 1) == 0) ? cur_start : pick_byte();
            send_byte(b, i == n - 1 || $urandom_range(0, 7) == 0);
        end
    endtask

    // Drop valid and wait until every decoded result has come out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Switch delimiters while idle, then run random traffic
    task automatic run_setting(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                               input int n_items, input bit with_long);
        int stop_at;
        drain_results();
        write_reg(CFG_START, s);
        write_reg(CFG_ESCAPE, e);
        cur_start = s;
        cur_esc   = e;
        stop_at   = bytes_sent + n_items;
        // one frame long enough to saturate the count
        if (with_long) send_frame($urandom_range(258, 270));
        while (bytes_sent < stop_at) begin
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) send_frame($urandom_range(0, 12));
            else send_noise($urandom_range(1, 10));
        end
    endtask

    // Result side: random stalls, plus one long hold-off to fill the block
    initial begin
        int burst;
        int hold_left;
        bit held;
        burst     = 0;
        hold_left = 0;
        held      = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && bytes_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] e;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= '0;
        in_ch.is_final <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_START;
        cfg_data       <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed script on the reset delimiters
        foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);

        // delimiter extremes both ways
        run_setting(8'h00, 8'hFF, 180, 1'b0);
        run_setting(8'hFF, 8'h00, 180, 1'b0);

        // equal delimiters
        s = BYTE_W'($urandom_range(0, 255));
        run_setting(s, s, 150, 1'b0);

        // random distinct delimiters, with a saturating frame
        s = BYTE_W'($urandom_range(0, 255));
        do e = BYTE_W'($urandom_range(0, 255)); while (e == s);
        run_setting(s, e, 400, 1'b1);

        // back to the reset values, no idling to the end
        quiet   = 1'b1;
        idle_on = 1'b0;
        run_setting(START_RESET, ESCAPE_RESET, 180, 1'b0);

        drain_results();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
